// File: design/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tsu_pkg.sv
// Types and constants of the tilde string unescaper.
// No dependencies; used by the interfaces, decode, result buffer and top level.
`default_nettype none

package tsu_pkg;

    localparam int LEN_W   = 13;
    localparam int LIMIT_W = 12;
    localparam int BYTE_W  = 8;
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;
    localparam int POS_W   = 2;

    localparam logic [BYTE_W-1:0] BYTE_LEAD_MIN = 8'h81;
    localparam logic [BYTE_W-1:0] BYTE_TILDE    = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_ANGLE    = 8'h3C;
    localparam logic [BYTE_W-1:0] BYTE_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_BRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] BYTE_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_VT       = 8'h0B;
    localparam logic [BYTE_W-1:0] BYTE_FF       = 8'h0C;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_EOF  = 2'd2,
        KIND_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_kind             kind;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        t_result [MAX_RES-1:0]     res;
    } t_run;

    typedef struct packed {
        logic             in_body;
        logic             lead_byte_seen;
        logic             angle_pending;
        logic [LEN_W-1:0] body_length;
    } t_state;

endpackage

`default_nettype wire

// File: design/tsu_if.sv
// Valid/ready channel interfaces: input bytes, results and the limit register write.
// Depends on tsu_pkg for field widths.
`default_nettype none

interface tsu_in_if;
    logic                      valid;
    logic                      ready;
    logic [tsu_pkg::BYTE_W-1:0] in_byte;
    logic                      end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface tsu_out_if;
    logic                      valid;
    logic                      ready;
    logic [tsu_pkg::BYTE_W-1:0] out_byte;
    logic [1:0]                kind;
    logic                      last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last_of_run,
                    output ready);
endinterface

interface tsu_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tsu_pkg::LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/tsu_decode.sv
// Single-pass decode of one input byte into up to four results and the next state.
// Depends on tsu_pkg.
`default_nettype none

module tsu_decode (
    input  wire logic [tsu_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                        i_eoi,
    input  wire tsu_pkg::t_state             i_state,
    input  wire logic [tsu_pkg::LIMIT_W-1:0] i_limit,
    output tsu_pkg::t_run                    o_run,
    output tsu_pkg::t_state                  o_state
);

    function automatic logic is_blank(input logic [tsu_pkg::BYTE_W-1:0] b);
        return b == tsu_pkg::BYTE_SPACE || b == tsu_pkg::BYTE_TAB ||
               b == tsu_pkg::BYTE_LF    || b == tsu_pkg::BYTE_VT  ||
               b == tsu_pkg::BYTE_FF    || b == tsu_pkg::BYTE_CR;
    endfunction

    function automatic tsu_pkg::t_run push(input tsu_pkg::t_run r, input tsu_pkg::t_kind k,
                                           input logic [tsu_pkg::BYTE_W-1:0] b);
        tsu_pkg::t_run n;
        n = r;
        n.res[r.cnt[tsu_pkg::POS_W-1:0]].out_byte = b;
        n.res[r.cnt[tsu_pkg::POS_W-1:0]].kind     = k;
        n.cnt = r.cnt + tsu_pkg::CNT_W'(1);
        return n;
    endfunction

    tsu_pkg::t_run   run;
    tsu_pkg::t_state st;
    logic            check;
    logic            skip;
    logic            core;
    logic            ended;
    logic            prev_lead;

    always_comb begin
        run       = '0;
        st        = i_state;
        check     = 1'b0;
        skip      = !i_state.in_body;
        core      = 1'b0;
        ended     = 1'b0;
        prev_lead = 1'b0;

        // pending single '<'
        if (i_state.in_body && i_state.angle_pending) begin
            st.angle_pending = 1'b0;
            if (i_byte == tsu_pkg::BYTE_ANGLE) begin
                run = push(run, tsu_pkg::KIND_DATA, tsu_pkg::BYTE_ESC);
                run = push(run, tsu_pkg::KIND_DATA, tsu_pkg::BYTE_BRACKET);
                st.body_length    = st.body_length + tsu_pkg::LEN_W'(2);
                st.lead_byte_seen = 1'b0;
                if (i_eoi) begin
                    run = push(run, tsu_pkg::KIND_EOF, '0);
                    st  = '0;
                end
            end else begin
                run = push(run, tsu_pkg::KIND_DATA, tsu_pkg::BYTE_ANGLE);
                st.body_length = st.body_length + tsu_pkg::LEN_W'(1);
                if (i_eoi) begin
                    run = push(run, tsu_pkg::KIND_EOF, '0);
                    st  = '0;
                end else begin
                    check = 1'b1;
                end
            end
        end else if (i_state.in_body) begin
            check = 1'b1;
        end

        // length check ahead of a body byte
        if (check) begin
            if (st.body_length > {1'b0, i_limit}) begin
                run  = push(run, tsu_pkg::KIND_LONG, '0);
                st   = '0;
                skip = 1'b1;
            end else begin
                core = 1'b1;
            end
        end

        // skip phase
        if (skip) begin
            if (i_byte == tsu_pkg::BYTE_TILDE) begin
                run = push(run, tsu_pkg::KIND_DONE, '0);
                st  = '0;
            end else if (i_eoi) begin
                run = push(run, tsu_pkg::KIND_EOF, '0);
                st  = '0;
            end else if (!is_blank(i_byte)) begin
                st         = '0;
                st.in_body = 1'b1;
                core       = 1'b1;
            end
        end

        // body byte
        if (core) begin
            prev_lead         = st.lead_byte_seen;
            st.lead_byte_seen = prev_lead ? 1'b0 : (i_byte >= tsu_pkg::BYTE_LEAD_MIN);
            if (i_byte == tsu_pkg::BYTE_LF) begin
                run = push(run, tsu_pkg::KIND_DATA, tsu_pkg::BYTE_LF);
                run = push(run, tsu_pkg::KIND_DATA, tsu_pkg::BYTE_CR);
                st.body_length = st.body_length + tsu_pkg::LEN_W'(2);
            end else if (i_byte == tsu_pkg::BYTE_CR) begin
                st.body_length = st.body_length;
            end else if (i_byte == tsu_pkg::BYTE_ANGLE) begin
                st.angle_pending = 1'b1;
            end else if (i_byte == tsu_pkg::BYTE_TILDE && !prev_lead) begin
                run   = push(run, tsu_pkg::KIND_DONE, '0);
                st    = '0;
                ended = 1'b1;
            end else begin
                run = push(run, tsu_pkg::KIND_DATA, i_byte);
                st.body_length = st.body_length + tsu_pkg::LEN_W'(1);
            end
            if (i_eoi && !ended) begin
                if (st.angle_pending) begin
                    run = push(run, tsu_pkg::KIND_DATA, tsu_pkg::BYTE_ANGLE);
                end
                run = push(run, tsu_pkg::KIND_EOF, '0);
                st  = '0;
            end
        end
    end

    assign o_run   = run;
    assign o_state = st;

endmodule

`default_nettype wire

// File: design/tsu_runbuf.sv
// Result buffer: holds the results of one byte and hands them out one per cycle while the output is ready.
// Depends on tsu_pkg and tsu_out_if.
`default_nettype none

module tsu_runbuf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire tsu_pkg::t_run i_run,
    output logic               o_free,
    tsu_out_if.source          o_out
);

    logic [tsu_pkg::CNT_W-1:0]          r_left;
    logic [tsu_pkg::POS_W-1:0]          r_pos;
    tsu_pkg::t_result [tsu_pkg::MAX_RES-1:0] r_res;
    logic                               fire;

    assign o_out.valid       = r_left != '0;
    assign o_out.out_byte    = r_res[r_pos].out_byte;
    assign o_out.kind        = r_res[r_pos].kind;
    assign o_out.last_of_run = r_left == tsu_pkg::CNT_W'(1);

    assign fire   = o_out.valid && o_out.ready;
    assign o_free = (r_left == '0) || (r_left == tsu_pkg::CNT_W'(1) && fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= '0;
        end else if (i_load) begin
            r_left <= i_run.cnt;
            r_pos  <= '0;
        end else if (fire) begin
            r_left <= r_left - tsu_pkg::CNT_W'(1);
            r_pos  <= r_pos + tsu_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_run.res;
        end
    end

endmodule

`default_nettype wire

// File: design/tilde_string_unescaper.sv
// Tilde string unescaper: takes one raw byte per transfer and returns the string bytes
// and end markers it causes, one result per output transfer. A byte enters the input
// register, is decoded in one pass and its zero to four results are loaded into the
// result buffer once it is free. One byte per cycle is sustained while each byte
// gives at most one result and the output is ready; a byte with n results (n from 1 to 4)
// holds the result buffer until all n have transferred, since it drains one result per
// output transfer. Bytes that give no result (skip-phase blanks, CR) pass at one per cycle
// while the result buffer is free. The limit register takes a write in any cycle.
// Depends on tsu_pkg, tsu_if, tsu_decode, tsu_runbuf and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tilde_string_unescaper #(
    parameter int MAX_LEN = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsu_in_if.sink    i_in,
    tsu_cfg_if.sink   i_cfg,
    tsu_out_if.source o_out
);

    localparam int LimitRst = (MAX_LEN - 5 > 4095) ? 4095 : MAX_LEN - 5;

    logic                        r_in_valid;
    logic [tsu_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_eoi;
    tsu_pkg::t_state             r_state;
    logic [tsu_pkg::LIMIT_W-1:0] r_limit;

    tsu_pkg::t_run               dec_run;
    tsu_pkg::t_state             n_state;
    logic                        buf_free;
    logic                        adv;
    logic                        in_fire;

    assign adv        = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || buf_free;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_limit    <= tsu_pkg::LIMIT_W'(LimitRst);
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_state <= n_state;
            end
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    tsu_decode u_decode (
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .i_state (r_state),
        .i_limit (r_limit),
        .o_run   (dec_run),
        .o_state (n_state)
    );

    tsu_runbuf u_runbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_run   (dec_run),
        .o_free  (buf_free),
        .o_out   (o_out)
    );

    `ASSERT_RST(a_skip_clear, i_clk, i_rst_n,
        !r_state.in_body |-> (!r_state.angle_pending && !r_state.lead_byte_seen &&
        r_state.body_length == '0), "skip phase state not cleared")

    `ASSERT_RST(a_marker_zero, i_clk, i_rst_n,
        (o_out.valid && o_out.kind != tsu_pkg::KIND_DATA) |-> o_out.out_byte == '0,
        "marker result carries a nonzero byte")

    `ASSERT_RST(a_end_last, i_clk, i_rst_n,
        (o_out.valid && !o_out.last_of_run) |->
        (o_out.kind == tsu_pkg::KIND_DATA || o_out.kind == tsu_pkg::KIND_LONG),
        "string end not last of its run")

    `ASSERT_NEXT(a_drain, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.last_of_run && !adv, !o_out.valid,
        "result shown after run drained")

endmodule

`default_nettype wire
